[hdl/multi_policy_cpu_scheduler_macros.svh]
// Assertion helpers for the scheduler datapath.
`ifndef MULTI_POLICY_CPU_SCHEDULER_MACROS_SVH
`define MULTI_POLICY_CPU_SCHEDULER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Consequent must hold in the cycle after the antecedent.
`define MPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

[hdl/mps_pkg.sv]
`default_nettype none

package mps_pkg;

    // Default ready queue depth.
    localparam int DEF_QUEUE_DEPTH = 16;

    // Saturation limit of the wait counter.
    localparam logic [23:0] WAIT_MAX = 24'hFFFFFF;

    // Policy codes.
    localparam logic [2:0] POL_FCFS = 3'd0;
    localparam logic [2:0] POL_SJF  = 3'd1;
    localparam logic [2:0] POL_HRRN = 3'd2;
    localparam logic [2:0] POL_RR   = 3'd3;
    localparam logic [2:0] POL_PRIO = 3'd4;

    // Item function codes.
    localparam logic FUNC_ARRIVAL = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    // Configuration register indexes.
    localparam logic REG_POLICY  = 1'b0;
    localparam logic REG_QUANTUM = 1'b1;

    // One queued or running process.
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] burst;
        logic [15:0] left;
        logic [23:0] wait_cnt;
        logic [7:0]  prio;
        logic [31:0] arrive;
    } t_entry;

    // Which logical queue slot the memory read port looks at.
    typedef enum logic [1:0] {
        RSEL_I,
        RSEL_J,
        RSEL_ZERO
    } t_rsel;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_ARR,
        S_TICK,
        S_P_RDI,
        S_P_LDI,
        S_P_RDJ,
        S_P_MUL,
        S_P_CMP,
        S_P_SW1,
        S_P_SW2,
        S_D_RD,
        S_D_LD,
        S_ADV,
        S_W_RD,
        S_W_WR,
        S_RUN,
        S_MOD,
        S_RR,
        S_FIN
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic  latch_in;
        logic  do_arr;
        logic  sort_init;
        logic  ld_first;
        logic  mul;
        logic  cmp;
        logic  sw1;
        logic  sw2;
        logic  disp;
        logic  adv;
        logic  winc;
        logic  run;
        logic  mod_init;
        logic  mod_step;
        logic  rr;
        logic  load_out;
        t_rsel rsel;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic func;
        logic need_disp;
        logic sort_pol;
        logic cnt_gt1;
        logic j_last;
        logic pass_more;
        logic cnt_zero;
        logic w_last;
        logic rr_pol;
        logic mod_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

[hdl/mps_ctrl.sv]
`default_nettype none

module mps_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    input  mps_pkg::t_sts i_sts,
    output mps_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);
    import mps_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.rsel = RSEL_I;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state = S_TICK;
                end
            end
            S_TICK: begin
                if (i_sts.func == FUNC_ARRIVAL) begin
                    n_state = S_ARR;
                end else if (i_sts.need_disp && i_sts.sort_pol && i_sts.cnt_gt1) begin
                    o_cmd.sort_init = 1'b1;
                    n_state = S_P_RDI;
                end else if (i_sts.need_disp) begin
                    n_state = S_D_RD;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_ARR: begin
                o_cmd.do_arr = 1'b1;
                n_state = S_FIN;
            end
            S_P_RDI: begin
                o_cmd.rsel = RSEL_I;
                n_state = S_P_LDI;
            end
            S_P_LDI: begin
                o_cmd.ld_first = 1'b1;
                n_state = S_P_RDJ;
            end
            S_P_RDJ: begin
                o_cmd.rsel = RSEL_J;
                n_state = S_P_MUL;
            end
            S_P_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_P_CMP;
            end
            S_P_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state = i_sts.j_last ? S_P_SW1 : S_P_RDJ;
            end
            S_P_SW1: begin
                o_cmd.sw1 = 1'b1;
                n_state = S_P_SW2;
            end
            S_P_SW2: begin
                o_cmd.sw2 = 1'b1;
                n_state = i_sts.pass_more ? S_P_RDI : S_D_RD;
            end
            S_D_RD: begin
                o_cmd.rsel = RSEL_ZERO;
                n_state = S_D_LD;
            end
            S_D_LD: begin
                o_cmd.disp = 1'b1;
                n_state = S_ADV;
            end
            S_ADV: begin
                o_cmd.adv = 1'b1;
                n_state = i_sts.cnt_zero ? S_RUN : S_W_RD;
            end
            S_W_RD: begin
                o_cmd.rsel = RSEL_I;
                n_state = S_W_WR;
            end
            S_W_WR: begin
                o_cmd.winc = 1'b1;
                n_state = i_sts.w_last ? S_RUN : S_W_RD;
            end
            S_RUN: begin
                o_cmd.run = 1'b1;
                o_cmd.mod_init = 1'b1;
                n_state = i_sts.rr_pol ? S_MOD : S_FIN;
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = S_RR;
                end
            end
            S_RR: begin
                o_cmd.rr = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/mps_dp.sv]
`default_nettype none
`include "multi_policy_cpu_scheduler_macros.svh"

module mps_dp #(
    parameter int QUEUE_DEPTH = mps_pkg::DEF_QUEUE_DEPTH
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  mps_pkg::t_cmd i_cmd,
    output mps_pkg::t_sts o_sts,
    input  wire           i_cfg_we,
    input  wire           i_cfg_index,
    input  wire  [7:0]    i_cfg_wdata,
    input  wire           i_func,
    input  wire  [7:0]    i_proc_id,
    input  wire  [31:0]   i_arrive_at,
    input  wire  [15:0]   i_burst,
    input  wire  [7:0]    i_prio,
    output logic          o_out_valid,
    input  wire           i_out_stall,
    output logic          o_status,
    output logic [7:0]    o_running_id,
    output logic          o_done_res,
    output logic [7:0]    o_done_id,
    output logic [31:0]   o_done_time,
    output logic [31:0]   o_turnaround,
    output logic [23:0]   o_wait_ticks
);
    import mps_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;

    // Queue memory, a ring addressed from the head pointer.
    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rd_data;

    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_k;
    t_entry        r_best;
    t_entry        r_first;
    t_entry        r_cand;
    logic [40:0]   r_pa;
    logic [40:0]   r_pb;
    t_entry        r_runner;
    logic          r_run_valid;
    logic [31:0]   r_now;
    logic [7:0]    r_rem;
    logic [4:0]    r_bit;
    logic [2:0]    r_policy;
    logic [7:0]    r_quantum;

    logic          r_func;
    t_entry        r_new;

    logic          r_res_status;
    logic          r_res_done;
    logic [7:0]    r_res_id;
    logic [31:0]   r_res_fin;
    logic [31:0]   r_res_tat;
    logic [23:0]   r_res_wt;

    logic          r_out_valid;
    logic          r_out_status;
    logic [7:0]    r_out_run_id;
    logic          r_out_done;
    logic [7:0]    r_out_done_id;
    logic [31:0]   r_out_fin;
    logic [31:0]   r_out_tat;
    logic [23:0]   r_out_wt;

    // Logical slot to physical address.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] slot);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(slot);
        if (sum >= SW'(QUEUE_DEPTH)) begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic          full;
    logic          pol_prio;
    logic          preempt;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic          ahead;
    logic [24:0]   sum_c;
    logic [24:0]   sum_b;
    logic [40:0]   prod_a;
    logic [40:0]   prod_b;
    logic [15:0]   left_n;
    logic [7:0]    qs;
    logic [8:0]    mod_t;
    logic          rr_take;
    t_entry        winc_data;

    // Decode and address helpers.
    always_comb begin
        full     = (r_count == CW'(QUEUE_DEPTH));
        pol_prio = (r_policy == POL_PRIO);
        preempt  = pol_prio && r_run_valid && (r_new.prio > r_runner.prio);
        head_dec = (r_head == '0) ? AW'(QUEUE_DEPTH - 1) : AW'(r_head - 1'b1);
        head_inc = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : AW'(r_head + 1'b1);
        left_n   = (r_runner.left != '0) ? (r_runner.left - 16'd1) : 16'd0;
        qs       = (r_quantum == '0) ? 8'd1 : r_quantum;
        mod_t    = {r_rem, r_now[r_bit]};
        if (mod_t >= {1'b0, qs}) begin
            mod_t = mod_t - {1'b0, qs};
        end
        rr_take  = r_run_valid && (r_rem == '0) && !full;
        winc_data = r_rd_data;
        if (r_rd_data.wait_cnt != WAIT_MAX) begin
            winc_data.wait_cnt = r_rd_data.wait_cnt + 24'd1;
        end
    end

    // Read address selection.
    always_comb begin
        unique case (i_cmd.rsel)
            RSEL_I:    rd_addr = phys(r_head, r_i);
            RSEL_J:    rd_addr = phys(r_head, r_j);
            RSEL_ZERO: rd_addr = r_head;
            default:   rd_addr = r_head;
        endcase
    end

    // Write port selection.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = phys(r_head, r_count);
        wr_data = r_new;
        priority if (i_cmd.do_arr) begin
            if (preempt && !full) begin
                wr_en   = 1'b1;
                wr_addr = head_dec;
                wr_data = r_runner;
            end else if (!(pol_prio && !r_run_valid) && !preempt && !full) begin
                wr_en   = 1'b1;
            end
        end else if (i_cmd.sw1) begin
            wr_en   = (r_k != r_i);
            wr_addr = phys(r_head, r_k);
            wr_data = r_first;
        end else if (i_cmd.sw2) begin
            wr_en   = 1'b1;
            wr_addr = phys(r_head, r_i);
            wr_data = r_best;
        end else if (i_cmd.winc) begin
            wr_en   = 1'b1;
            wr_addr = phys(r_head, r_i);
            wr_data = winc_data;
        end else if (i_cmd.rr) begin
            wr_en   = rr_take;
            wr_data = r_runner;
        end
    end

    // Queue memory port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Response ratio products for the candidate and the current best.
    always_comb begin
        sum_c  = 25'(r_rd_data.wait_cnt) + 25'(r_rd_data.burst);
        sum_b  = 25'(r_best.wait_cnt) + 25'(r_best.burst);
        prod_a = 41'(sum_c) * 41'(r_best.burst);
        prod_b = 41'(sum_b) * 41'(r_rd_data.burst);
    end

    // Policy key compare, candidate against best.
    always_comb begin
        unique case (r_policy)
            POL_SJF:  ahead = (r_cand.burst < r_best.burst);
            POL_HRRN: ahead = (r_pa > r_pb);
            POL_PRIO: ahead = (r_cand.prio > r_best.prio);
            default:  ahead = 1'b0;
        endcase
    end

    // Sort registers, modulo unit registers and item payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_func         <= i_func;
            r_new.id       <= i_proc_id;
            r_new.arrive   <= i_arrive_at;
            r_new.burst    <= i_burst;
            r_new.left     <= i_burst;
            r_new.wait_cnt <= '0;
            r_new.prio     <= i_prio;
        end
        if (i_cmd.sort_init || i_cmd.adv) begin
            r_i <= '0;
        end else if (i_cmd.sw2 || i_cmd.winc) begin
            r_i <= CW'(r_i + 1'b1);
        end
        if (i_cmd.ld_first) begin
            r_best  <= r_rd_data;
            r_first <= r_rd_data;
            r_k     <= r_i;
            r_j     <= CW'(r_i + 1'b1);
        end
        if (i_cmd.mul) begin
            r_cand <= r_rd_data;
            r_pa   <= prod_a;
            r_pb   <= prod_b;
        end
        if (i_cmd.cmp) begin
            if (ahead) begin
                r_best <= r_cand;
                r_k    <= r_j;
            end
            r_j <= CW'(r_j + 1'b1);
        end
        if (i_cmd.mod_init) begin
            r_rem <= '0;
            r_bit <= 5'd31;
        end else if (i_cmd.mod_step) begin
            r_rem <= mod_t[7:0];
            r_bit <= r_bit - 5'd1;
        end
    end

    // Results of the current item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_res_status <= 1'b0;
            r_res_done   <= 1'b0;
            r_res_id     <= '0;
            r_res_fin    <= '0;
            r_res_tat    <= '0;
            r_res_wt     <= '0;
        end else if (i_cmd.do_arr) begin
            if (!(pol_prio && !r_run_valid) && full) begin
                r_res_status <= 1'b1;
            end
        end else if (i_cmd.run && r_run_valid && (left_n == '0)) begin
            r_res_done <= 1'b1;
            r_res_id   <= r_runner.id;
            r_res_fin  <= r_now;
            r_res_tat  <= r_now - r_runner.arrive;
            r_res_wt   <= r_runner.wait_cnt;
        end
    end

    // Runner payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_arr) begin
            if ((pol_prio && !r_run_valid) || (preempt && !full)) begin
                r_runner <= r_new;
            end
        end else if (i_cmd.disp) begin
            r_runner <= r_rd_data;
        end else if (i_cmd.run && r_run_valid) begin
            r_runner.left <= left_n;
        end
    end

    // Control state: queue pointers, runner flag, time, configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_run_valid <= 1'b0;
            r_now       <= '0;
            r_policy    <= POL_FCFS;
            r_quantum   <= 8'd1;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_POLICY) begin
                    r_policy <= i_cfg_wdata[2:0];
                end else begin
                    r_quantum <= i_cfg_wdata;
                end
            end
            if (i_cmd.do_arr) begin
                if (pol_prio && !r_run_valid) begin
                    r_run_valid <= 1'b1;
                end else if (preempt && !full) begin
                    r_head  <= head_dec;
                    r_count <= CW'(r_count + 1'b1);
                end else if (!full) begin
                    r_count <= CW'(r_count + 1'b1);
                end
            end
            if (i_cmd.disp) begin
                r_head      <= head_inc;
                r_count     <= CW'(r_count - 1'b1);
                r_run_valid <= 1'b1;
            end
            if (i_cmd.adv) begin
                r_now <= r_now + 32'd1;
            end
            if (i_cmd.run && r_run_valid && (left_n == '0)) begin
                r_run_valid <= 1'b0;
            end
            if (i_cmd.rr && rr_take) begin
                r_count     <= CW'(r_count + 1'b1);
                r_run_valid <= 1'b0;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status  <= r_res_status;
            r_out_run_id  <= r_run_valid ? r_runner.id : 8'd0;
            r_out_done    <= r_res_done;
            r_out_done_id <= r_res_id;
            r_out_fin     <= r_res_fin;
            r_out_tat     <= r_res_tat;
            r_out_wt      <= r_res_wt;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_running_id  = r_out_run_id;
    assign o_done_res    = r_out_done;
    assign o_done_id     = r_out_done_id;
    assign o_done_time   = r_out_fin;
    assign o_turnaround  = r_out_tat;
    assign o_wait_ticks  = r_out_wt;

    // Status toward the controller.
    always_comb begin
        o_sts.func      = r_func;
        o_sts.need_disp = !r_run_valid && (r_count != '0);
        o_sts.sort_pol  = (r_policy == POL_SJF) || (r_policy == POL_HRRN) || pol_prio;
        o_sts.cnt_gt1   = (r_count > CW'(1));
        o_sts.j_last    = (SW'(r_j) + SW'(1) == SW'(r_count));
        o_sts.pass_more = (SW'(r_i) + SW'(2) < SW'(r_count));
        o_sts.cnt_zero  = (r_count == '0);
        o_sts.w_last    = (SW'(r_i) + SW'(1) == SW'(r_count));
        o_sts.rr_pol    = (r_policy == POL_RR);
        o_sts.mod_last  = (r_bit == '0);
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    // Checks.
    `MPS_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(QUEUE_DEPTH))
    `MPS_ASSERT_NEXT(a_disp_runs, i_clk, i_rst_n, i_cmd.disp, r_run_valid)
    `MPS_ASSERT_SAME(a_drop_on_arrival, i_clk, i_rst_n, i_cmd.load_out && r_res_status, r_func == FUNC_ARRIVAL)

endmodule

`default_nettype wire

[hdl/multi_policy_cpu_scheduler.sv]
// An arrival word passes the controller states TICK, ARR and FIN; the next word is
// taken once the result is loaded into the output register, so one word is in flight.
// A tick walks TICK, an optional dispatch (D_RD, D_LD), ADV, a wait update (W_RD,
// W_WR) per queued entry, RUN, the modulo unit (MOD, RR) under round robin, and FIN.
// Sorting before a dispatch is a selection sort with P_RDJ, P_MUL and P_CMP a compare.
// Sync active-low reset clears time, queue, runner, output and registers.
`default_nettype none

module multi_policy_cpu_scheduler #(
    parameter int QUEUE_DEPTH = mps_pkg::DEF_QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire  [7:0]  i_cfg_wdata,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_func,
    input  wire  [7:0]  i_proc_id,
    input  wire  [31:0] i_arrive_at,
    input  wire  [15:0] i_burst,
    input  wire  [7:0]  i_prio,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_status,
    output logic [7:0]  o_running_id,
    output logic        o_done_res,
    output logic [7:0]  o_done_id,
    output logic [31:0] o_done_time,
    output logic [31:0] o_turnaround,
    output logic [23:0] o_wait_ticks
);
    import mps_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    mps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Queue, runner and result datapath.
    mps_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_func        (i_func),
        .i_proc_id     (i_proc_id),
        .i_arrive_at   (i_arrive_at),
        .i_burst       (i_burst),
        .i_prio        (i_prio),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_running_id  (o_running_id),
        .o_done_res    (o_done_res),
        .o_done_id     (o_done_id),
        .o_done_time   (o_done_time),
        .o_turnaround  (o_turnaround),
        .o_wait_ticks  (o_wait_ticks)
    );

endmodule

`default_nettype wire
